// ===== sv/udaf_pkg.sv =====
package udaf_pkg;

	localparam int ValueWidth    = 32;
	localparam int Digits        = 10;
	localparam int DigitWidth    = 4;
	localparam int BcdWidth      = Digits * DigitWidth;
	localparam int WordWidth     = BcdWidth + ValueWidth;
	localparam int StepsPerStage = 4;
	localparam int NumStages     = ValueWidth / StepsPerStage;
	localparam int CharWidth     = 6;
	localparam int PosWidth      = $clog2(Digits);

	localparam logic [CharWidth-1:0] AsciiZero = 6'h30;
	localparam logic [PosWidth-1:0]  LastPos   = PosWidth'(Digits - 1);

	typedef logic [DigitWidth-1:0] digit_t;

	// Index 0 is the most significant digit.
	typedef digit_t [Digits-1:0] bcd_t;

	typedef struct packed {
		logic valid;
		bcd_t digits;
	} conv_beat_t;

endpackage

// ===== sv/unsigned_decimal_ascii_formatter_top.sv =====
// Prints an unsigned 32-bit value as decimal ASCII digits, most significant digit first,
// with leading zeros suppressed (zero prints as a single '0'). A value is taken when start
// is high and busy is low. Each character is shown for exactly one cycle with strobe high,
// and last marks the units digit; the receiver cannot stall, so it must take every strobe.
// A value with more decimal digits occupies the character port for longer, so the
// one-character-per-cycle output serializer sets the sustained rate. When the serializer
// is free, the first character of a value passes through eight conversion stages and
// then the serializer register.
module unsigned_decimal_ascii_formatter_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [udaf_pkg::ValueWidth-1:0]   value,
	output logic                              strobe,
	output logic [udaf_pkg::CharWidth-1:0]    digit_char,
	output logic                              last
);

	// The converter is a binary-to-BCD shift-and-add-3 pipeline, four bit steps per stage.
	// Stages hold their beat when the serializer is still printing, and busy goes high
	// only once every stage ahead of the input is occupied.
	udaf_pkg::conv_beat_t conv_beat;
	logic                 ser_ready;

	udaf_b2d_pipe u_b2d (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.value     (value),
		.busy      (busy),
		.out_ready (ser_ready),
		.conv_out  (conv_beat)
	);

	// The serializer takes the next converted value in the same cycle that it prints
	// the units digit of the current one, so characters of back-to-back values run
	// without a gap.
	udaf_serializer u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.conv_in    (conv_beat),
		.in_ready   (ser_ready),
		.strobe     (strobe),
		.digit_char (digit_char),
		.last       (last)
	);

endmodule

// ===== sv/udaf_b2d_pipe.sv =====
module udaf_b2d_pipe (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [udaf_pkg::ValueWidth-1:0]   value,
	output logic                              busy,
	input  logic                              out_ready,
	output udaf_pkg::conv_beat_t              conv_out
);

	localparam int N = udaf_pkg::NumStages;

	// Shift-and-add-3 over a group of bit steps; nibble corrections are independent.
	function automatic logic [udaf_pkg::WordWidth-1:0] dd_steps(
		input logic [udaf_pkg::WordWidth-1:0] w_in
	);
		logic [udaf_pkg::WordWidth-1:0] w;
		w = w_in;
		for (int s = 0; s < udaf_pkg::StepsPerStage; s++) begin
			for (int k = 0; k < udaf_pkg::Digits; k++) begin
				if (w[udaf_pkg::ValueWidth + udaf_pkg::DigitWidth*k +: udaf_pkg::DigitWidth]
						>= udaf_pkg::DigitWidth'(5)) begin
					w[udaf_pkg::ValueWidth + udaf_pkg::DigitWidth*k +: udaf_pkg::DigitWidth] =
						w[udaf_pkg::ValueWidth + udaf_pkg::DigitWidth*k +: udaf_pkg::DigitWidth]
						+ udaf_pkg::DigitWidth'(3);
				end
			end
			w = {w[udaf_pkg::WordWidth-2:0], 1'b0};
		end
		return w;
	endfunction

	logic [udaf_pkg::WordWidth-1:0] word_s [N];
	logic [N-1:0]                   vld_s;
	logic [N:0]                     stage_ready;
	logic [udaf_pkg::BcdWidth-1:0]  bcd_flat;

	assign stage_ready[N] = out_ready;
	for (genvar i = 0; i < N; i++) begin : g_ready
		assign stage_ready[i] = !vld_s[i] || stage_ready[i+1];
	end

	assign busy = !stage_ready[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (stage_ready[0]) begin
				vld_s[0] <= start;
			end
			for (int i = 1; i < N; i++) begin
				if (stage_ready[i]) begin
					vld_s[i] <= vld_s[i-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stage_ready[0]) begin
			word_s[0] <= dd_steps({{udaf_pkg::BcdWidth{1'b0}}, value});
		end
		for (int i = 1; i < N; i++) begin
			if (stage_ready[i]) begin
				word_s[i] <= dd_steps(word_s[i-1]);
			end
		end
	end

	assign bcd_flat = word_s[N-1][udaf_pkg::WordWidth-1 -: udaf_pkg::BcdWidth];

	always_comb begin
		conv_out.valid = vld_s[N-1];
		for (int k = 0; k < udaf_pkg::Digits; k++) begin
			conv_out.digits[k] =
				bcd_flat[udaf_pkg::BcdWidth-1 - udaf_pkg::DigitWidth*k -: udaf_pkg::DigitWidth];
		end
	end

endmodule

// ===== sv/udaf_serializer.sv =====
module udaf_serializer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  udaf_pkg::conv_beat_t              conv_in,
	output logic                              in_ready,
	output logic                              strobe,
	output logic [udaf_pkg::CharWidth-1:0]    digit_char,
	output logic                              last
);

	udaf_pkg::bcd_t                  digits_q;
	logic [udaf_pkg::PosWidth-1:0]   pos_q;
	logic                            active_q;
	logic [udaf_pkg::PosWidth-1:0]   lead;
	logic                            load;

	// First nonzero digit from the top; the units digit always prints.
	always_comb begin
		lead = udaf_pkg::LastPos;
		for (int k = udaf_pkg::Digits - 2; k >= 0; k--) begin
			if (conv_in.digits[k] != '0) begin
				lead = udaf_pkg::PosWidth'(k);
			end
		end
	end

	assign in_ready = !active_q || (pos_q == udaf_pkg::LastPos);
	assign load     = in_ready && conv_in.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			pos_q    <= '0;
		end else if (load) begin
			active_q <= 1'b1;
			pos_q    <= lead;
		end else if (active_q) begin
			if (pos_q == udaf_pkg::LastPos) begin
				active_q <= 1'b0;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			digits_q <= conv_in.digits;
		end
	end

	assign strobe     = active_q;
	assign last       = active_q && (pos_q == udaf_pkg::LastPos);
	assign digit_char = udaf_pkg::AsciiZero
		| {{(udaf_pkg::CharWidth - udaf_pkg::DigitWidth){1'b0}}, digits_q[pos_q]};

endmodule

// ===== sv/udaf_checker.sv =====
module udaf_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              strobe,
	input logic [udaf_pkg::CharWidth-1:0]    digit_char,
	input logic                              last
);

	// The last marker only ever rides on a character beat.
	a_last_on_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> strobe)
		else $error("last without strobe");

	// Every character is a decimal digit.
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (digit_char >= 6'h30) && (digit_char <= 6'h39))
		else $error("character out of digit range");

	// The characters of one number come out in consecutive cycles.
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe)
		else $error("gap inside a number");

	// A zero that is not the units digit never opens a number.
	a_no_leading_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last && (digit_char == 6'h30) |-> $past(strobe && !last))
		else $error("leading zero printed");

endmodule

bind unsigned_decimal_ascii_formatter_top udaf_checker u_udaf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.strobe     (strobe),
	.digit_char (digit_char),
	.last       (last)
);
